// File: hw/rtl/frx_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frx_pkg: shared types and constants of the frame receiver
// Register set, command format between front and back, output channels.
// ---------------------------------------------------------------------------
package frx_pkg;

   // register indexes of the configuration port
   localparam logic [1:0] REG_SYNC_WORD   = 2'd0;
   localparam logic [1:0] REG_ACK_FLAGS   = 2'd1;
   localparam logic [1:0] REG_END_FLAGS   = 2'd2;
   localparam logic [1:0] REG_MAX_PAYLOAD = 2'd3;

   // reset values of the registers
   localparam logic [31:0] SYNC_RESET        = 32'hDCC0_23C2;
   localparam logic [7:0]  ACK_FLAGS_RESET   = 8'h80;
   localparam logic [7:0]  END_FLAGS_RESET   = 8'h40;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

   // result channels
   localparam logic [1:0] CH_FILE = 2'd0;
   localparam logic [1:0] CH_ACK  = 2'd1;
   localparam logic [1:0] CH_DONE = 2'd2;

   // header layout
   localparam logic [3:0] HDR_LEN_HI = 4'd10;
   localparam logic [3:0] HDR_LEN_LO = 4'd11;
   localparam logic [3:0] HDR_ID     = 4'd12;
   localparam logic [3:0] HDR_FLAGS  = 4'd13;

   // back end step numbers: data, fourteen ack bytes, done
   localparam logic [3:0] STEP_DATA      = 4'd0;
   localparam logic [3:0] STEP_ACK_FIRST = 4'd1;
   localparam logic [3:0] STEP_ACK_LAST  = 4'd14;
   localparam logic [3:0] STEP_DONE      = 4'd15;

   localparam int QUEUE_DEPTH = 2;

   // configuration register set
   typedef struct packed {
      logic [31:0] sync_word;
      logic [7:0]  ack_flags;
      logic [7:0]  end_flags;
      logic [15:0] max_payload;
   } cfg_type;

   // work for the back end caused by one received byte
   typedef struct packed {
      logic       has_data;
      logic [7:0] data;
      logic       has_ack;
      logic [7:0] ack_id;
      logic       has_done;
   } cmd_type;

endpackage

// File: hw/rtl/frx_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frx_front: header parser and payload classifier
// Collects headers, checks sync, tracks frame ids and payload counts, and
// turns each received byte into at most one command for the back end.
// ---------------------------------------------------------------------------
module frx_front (
   input  logic             clock,
   input  logic             reset,
   input  frx_pkg::cfg_type cfg,
   input  logic             rx_valid,
   input  logic [7:0]       rx_byte,
   output logic             cmd_push,
   output frx_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_DONE    = 3'b100
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [31:0] sync1_ff, sync1_in;
   logic [31:0] sync2_ff, sync2_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  flags_ff, flags_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  last_id_ff, last_id_in;
   logic        is_new_ff, is_new_in;

   logic [15:0] offset;
   logic [15:0] left_dec;
   logic        sync_ok;

   assign offset   = length_ff - left_ff;
   assign left_dec = left_ff - 16'd1;
   assign sync_ok  = (sync1_ff == cfg.sync_word) && (sync2_ff == cfg.sync_word);

   // per-byte parsing
   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      sync1_in   = sync1_ff;
      sync2_in   = sync2_ff;
      length_in  = length_ff;
      id_in      = id_ff;
      flags_in   = flags_ff;
      left_in    = left_ff;
      last_id_in = last_id_ff;
      is_new_in  = is_new_ff;
      cmd_push   = 1'b0;
      cmd        = '0;
      cmd.data   = rx_byte;
      cmd.ack_id = id_ff;
      if (rx_valid) begin
         unique case (phase_ff)
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            PH_PAYLOAD: begin
               cmd.has_data = is_new_ff && (offset < cfg.max_payload);
               left_in      = left_dec;
               if (left_dec == 16'd0) begin
                  cmd.has_ack  = 1'b1;
                  cmd.has_done = (flags_ff == cfg.end_flags);
                  phase_in     = cmd.has_done ? PH_DONE : PH_HEADER;
                  hdr_cnt_in   = 4'd0;
               end
               cmd_push = cmd.has_data || cmd.has_ack;
            end
            default: begin
               phase_in = PH_HEADER;
               if (hdr_cnt_ff < 4'd4) begin
                  sync1_in = {sync1_ff[23:0], rx_byte};
               end else if (hdr_cnt_ff < 4'd8) begin
                  sync2_in = {sync2_ff[23:0], rx_byte};
               end else if (hdr_cnt_ff == frx_pkg::HDR_LEN_HI) begin
                  length_in = {rx_byte, length_ff[7:0]};
               end else if (hdr_cnt_ff == frx_pkg::HDR_LEN_LO) begin
                  length_in = {length_ff[15:8], rx_byte};
               end else if (hdr_cnt_ff == frx_pkg::HDR_ID) begin
                  id_in = rx_byte;
               end else if (hdr_cnt_ff == frx_pkg::HDR_FLAGS) begin
                  flags_in = rx_byte;
               end
               if (hdr_cnt_ff != frx_pkg::HDR_FLAGS) begin
                  hdr_cnt_in = hdr_cnt_ff + 4'd1;
               end else begin
                  // last header byte: accept or drop the header
                  hdr_cnt_in = 4'd0;
                  if (sync_ok) begin
                     is_new_in = (id_ff != last_id_ff);
                     if (id_ff != last_id_ff) begin
                        last_id_in = id_ff;
                     end
                     left_in = length_ff;
                     if (length_ff == 16'd0) begin
                        cmd.has_ack  = 1'b1;
                        cmd.has_done = (rx_byte == cfg.end_flags);
                        cmd_push     = 1'b1;
                        phase_in     = cmd.has_done ? PH_DONE : PH_HEADER;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_cnt_ff <= 4'd0;
         sync1_ff   <= '0;
         sync2_ff   <= '0;
         length_ff  <= '0;
         id_ff      <= '0;
         flags_ff   <= '0;
         left_ff    <= '0;
         last_id_ff <= 8'd1;
         is_new_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         sync1_ff   <= sync1_in;
         sync2_ff   <= sync2_in;
         length_ff  <= length_in;
         id_ff      <= id_in;
         flags_ff   <= flags_in;
         left_ff    <= left_in;
         last_id_ff <= last_id_in;
         is_new_ff  <= is_new_in;
      end
   end

endmodule

// File: hw/rtl/frx_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frx_queue: short command queue between front and back
// Two entries, push on one side, pop on the other, same cycle unless full.
// ---------------------------------------------------------------------------
module frx_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  frx_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output frx_pkg::cmd_type head
);

   frx_pkg::cmd_type entry_ff [frx_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'(frx_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hw/rtl/frx_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frx_back: result sequencer
// Expands each command into its flagged data byte, acknowledge frame and done
// marker, one result per cycle into a registered output stage when free.
// ---------------------------------------------------------------------------
module frx_back (
   input  logic             clock,
   input  logic             reset,
   input  frx_pkg::cfg_type cfg,
   input  logic             q_not_empty,
   input  frx_pkg::cmd_type q_head,
   output logic             q_pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [1:0]       out_channel,
   output logic [7:0]       out_byte,
   output logic             out_last
);

   frx_pkg::cmd_type cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [3:0] step_ff, step_in;
   logic       oval_ff, oval_in;
   logic [1:0] och_ff, och_in;
   logic [7:0] obyte_ff, obyte_in;
   logic       olast_ff, olast_in;

   logic       stage_free;
   logic       emit;
   logic [3:0] end_step;
   logic       at_end;
   logic [3:0] start_step;
   logic [7:0] ack_byte;

   assign stage_free = !oval_ff || out_ready;
   assign emit       = cur_valid_ff && stage_free;
   assign end_step   = cur_ff.has_done ? frx_pkg::STEP_DONE :
                       (cur_ff.has_ack ? frx_pkg::STEP_ACK_LAST : frx_pkg::STEP_DATA);
   assign at_end     = (step_ff == end_step);
   assign q_pop      = q_not_empty && (!cur_valid_ff || (emit && at_end));
   assign start_step = q_head.has_data ? frx_pkg::STEP_DATA : frx_pkg::STEP_ACK_FIRST;

   // acknowledge frame byte for the current step
   always_comb begin
      unique case (step_ff)
         4'd1, 4'd5:  ack_byte = cfg.sync_word[31:24];
         4'd2, 4'd6:  ack_byte = cfg.sync_word[23:16];
         4'd3, 4'd7:  ack_byte = cfg.sync_word[15:8];
         4'd4, 4'd8:  ack_byte = cfg.sync_word[7:0];
         4'd13:       ack_byte = cur_ff.ack_id;
         4'd14:       ack_byte = cfg.ack_flags;
         default:     ack_byte = 8'd0;
      endcase
   end

   // sequencing and output stage
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      oval_in      = oval_ff && !out_ready;
      och_in       = och_ff;
      obyte_in     = obyte_ff;
      olast_in     = olast_ff;
      if (emit) begin
         oval_in  = 1'b1;
         olast_in = at_end;
         if (step_ff == frx_pkg::STEP_DATA) begin
            och_in   = frx_pkg::CH_FILE;
            obyte_in = cur_ff.data;
         end else if (step_ff == frx_pkg::STEP_DONE) begin
            och_in   = frx_pkg::CH_DONE;
            obyte_in = 8'd0;
         end else begin
            och_in   = frx_pkg::CH_ACK;
            obyte_in = ack_byte;
         end
         if (at_end) begin
            cur_valid_in = 1'b0;
         end else if (step_ff == frx_pkg::STEP_ACK_LAST) begin
            step_in = frx_pkg::STEP_DONE;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
      if (q_pop) begin
         cur_in       = q_head;
         cur_valid_in = 1'b1;
         step_in      = start_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= '0;
         oval_ff      <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         oval_ff      <= oval_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      och_ff   <= och_in;
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
   end

   assign out_valid   = oval_ff;
   assign out_channel = och_ff;
   assign out_byte    = obyte_ff;
   assign out_last    = olast_ff;

endmodule

// File: hw/rtl/frame_receiver_with_ack.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_receiver_with_ack: stop-and-wait frame receiver
// Parses framed link bytes, forwards new payload and answers with acks.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one received link byte per transaction. rsp_* carries the
//   results: tuser 0 file data, 1 acknowledge byte, 2 transfer done; tlast
//   marks the last result caused by one received byte. csr_* writes
//   sync_word (0), ack_flags (1), end_flags (2), max_payload (3) and is written
//   by the user while no results are pending; the block does not enforce it.
// Data path and throughput: a forwarded payload byte passes the queue
//   entry, the current command and the output registers before rsp. The
//   front takes one byte per cycle while the queue is not full; the back
//   sends one result per cycle unless rsp stalls. A frame end gives 14 to 16
//   results (data byte, acknowledge frame, done), covered by the 14 header
//   bytes of the next frame, so with a ready receiver req_tready stays high.
// Reset and stall:
//   reset clears the parser to header hunting, last id to one and the
//   registers to their defaults. A stalled rsp holds its result; the queue
//   absorbs two more byte commands before req_tready goes low.
//   After the done result every byte is accepted and dropped.
// ---------------------------------------------------------------------------
module frame_receiver_with_ack (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [1:0] out_channel
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   frx_pkg::cfg_type cfg_ff, cfg_in;
   frx_pkg::cmd_type push_cmd;
   frx_pkg::cmd_type q_head;
   logic             cmd_push;
   logic             q_full;
   logic             q_not_empty;
   logic             q_pop;
   logic             rx_valid;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            frx_pkg::REG_SYNC_WORD:   cfg_in.sync_word   = csr_wdata;
            frx_pkg::REG_ACK_FLAGS:   cfg_in.ack_flags   = csr_wdata[7:0];
            frx_pkg::REG_END_FLAGS:   cfg_in.end_flags   = csr_wdata[7:0];
            frx_pkg::REG_MAX_PAYLOAD: cfg_in.max_payload = csr_wdata[15:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_word   <= frx_pkg::SYNC_RESET;
         cfg_ff.ack_flags   <= frx_pkg::ACK_FLAGS_RESET;
         cfg_ff.end_flags   <= frx_pkg::END_FLAGS_RESET;
         cfg_ff.max_payload <= frx_pkg::MAX_PAYLOAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input transaction
   assign req_tready = !q_full;
   assign rx_valid   = req_tvalid && !q_full;

   frx_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .rx_valid (rx_valid),
      .rx_byte  (req_tdata),
      .cmd_push (cmd_push),
      .cmd      (push_cmd)
   );

   frx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   frx_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_channel (rsp_tuser),
      .out_byte    (rsp_tdata),
      .out_last    (rsp_tlast)
   );

endmodule
